// ===== sv/binary_heap_priority_queue_macros.svh =====
// Assertion macros shared by the heap queue RTL.
// Expect clk and arst_n in scope where they are used.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Check that the consequent holds in the same cycle
`define HBPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the next cycle
`define HBPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/hbpq_pkg.sv =====
// Shared types, codes and the ordering compare for the heap queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package hbpq_pkg;

	localparam int unsigned DATA_W       = 32;
	localparam int unsigned CAPACITY_DEF = 1024;

	typedef enum logic [1:0] {
		REQ_PUSH = 2'd0,
		REQ_POP  = 2'd1,
		REQ_PEEK = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// finished request handed from the sequencer to the output register
	typedef struct packed {
		logic                     vld;
		logic signed [DATA_W-1:0] value;
		status_t                  status;
	} seq_res_t;

	// true when a must sit above b: strictly greater, or strictly smaller in min-first order
	function automatic logic better(input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b, input logic min_first);
		return min_first ? (a < b) : (a > b);
	endfunction

endpackage

// ===== sv/hbpq_mem.sv =====
// Heap store: one write port, two read ports with registered read data.
// Depends on hbpq_pkg for the word width and default depth.
`timescale 1ns / 1ps

module hbpq_mem #(
	parameter int unsigned DEPTH = hbpq_pkg::CAPACITY_DEF,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic                              clk,
	input  logic                              wr_en,
	input  logic [AW-1:0]                     wr_addr,
	input  logic signed [hbpq_pkg::DATA_W-1:0] wr_data,
	input  logic [AW-1:0]                     rd_addr0,
	input  logic [AW-1:0]                     rd_addr1,
	output logic signed [hbpq_pkg::DATA_W-1:0] rd_data0,
	output logic signed [hbpq_pkg::DATA_W-1:0] rd_data1
);
	import hbpq_pkg::*;

	logic signed [DATA_W-1:0] mem_q [DEPTH];

	// write one word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// register both read words
	always_ff @(posedge clk) begin
		rd_data0 <= mem_q[rd_addr0];
		rd_data1 <= mem_q[rd_addr1];
	end

endmodule

// ===== sv/hbpq_seq.sv =====
// Request sequencer: count, sift-up and sift-down walks over the heap store.
// Depends on hbpq_pkg and binary_heap_priority_queue_macros.svh.
`timescale 1ns / 1ps
`include "binary_heap_priority_queue_macros.svh"

module hbpq_seq #(
	parameter int unsigned CAPACITY = hbpq_pkg::CAPACITY_DEF,
	localparam int unsigned SW = $clog2(CAPACITY + 1),
	localparam int unsigned AW = $clog2(CAPACITY)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               heap_order,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         req_type,
	input  logic signed [hbpq_pkg::DATA_W-1:0] value,
	output hbpq_pkg::seq_res_t                 res,
	output logic [SW-1:0]                      count,
	input  logic                               out_free,
	output logic [AW-1:0]                      rd_addr0,
	output logic [AW-1:0]                      rd_addr1,
	input  logic signed [hbpq_pkg::DATA_W-1:0] rd_data0,
	input  logic signed [hbpq_pkg::DATA_W-1:0] rd_data1,
	output logic                               wr_en,
	output logic [AW-1:0]                      wr_addr,
	output logic signed [hbpq_pkg::DATA_W-1:0] wr_data
);
	import hbpq_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_LOAD  = 6'b000010,
		S_UP    = 6'b000100,
		S_DOWN  = 6'b001000,
		S_PLACE = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	// heap slots run from 1; the store is addressed from 0
	function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] slot);
		logic [SW-1:0] idx;
		idx = slot - SW'(1);
		return idx[AW-1:0];
	endfunction

	state_t                   state_q, state_d;
	req_t                     req_q;
	logic signed [DATA_W-1:0] x_q;
	logic signed [DATA_W-1:0] res_value_q;
	status_t                  res_status_q;
	status_t                  stat_d;
	logic [SW-1:0]            pos_q;
	logic [SW-1:0]            count_q;

	logic                     accept;
	logic                     cnt_full;
	logic [SW-1:0]            cnt_inc;
	logic [SW-1:0]            cnt_dec;
	logic [SW-1:0]            up_par;
	logic                     up_go;
	logic [SW:0]              cnt_ext;
	logic [SW:0]              dn_l;
	logic [SW:0]              dn_r;
	logic [SW:0]              dn_next_l;
	logic                     dn_has_r;
	logic                     dn_lb;
	logic                     dn_rb;
	logic                     dn_go;
	logic                     dn_pick_r;
	logic                     dn_more;
	logic [SW-1:0]            dn_csel;
	logic signed [DATA_W-1:0] dn_cval;

	// take a word only between requests
	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);

	assign cnt_full = (count_q == SW'(CAPACITY));
	assign cnt_inc  = count_q + SW'(1);
	assign cnt_dec  = count_q - SW'(1);
	assign cnt_ext  = {1'b0, count_q};

	// sift up: moving word against its parent
	assign up_par = pos_q >> 1;
	assign up_go  = better(x_q, rd_data0, heap_order);

	// sift down: moving word against both children, left wins only when strictly better
	assign dn_l      = {pos_q, 1'b0};
	assign dn_r      = {pos_q, 1'b1};
	assign dn_has_r  = (dn_r <= cnt_ext);
	assign dn_lb     = better(rd_data0, x_q, heap_order);
	assign dn_rb     = dn_has_r && better(rd_data1, x_q, heap_order);
	assign dn_go     = dn_lb || dn_rb;
	assign dn_pick_r = dn_has_r && !better(rd_data0, rd_data1, heap_order);
	assign dn_csel   = dn_pick_r ? dn_r[SW-1:0] : dn_l[SW-1:0];
	assign dn_cval   = dn_pick_r ? rd_data1 : rd_data0;
	assign dn_next_l = {dn_csel, 1'b0};
	assign dn_more   = (dn_next_l <= cnt_ext);

	// status of a request at acceptance
	always_comb begin
		stat_d = STAT_OK;
		unique case (req_type)
			REQ_PUSH: if (cnt_full) stat_d = STAT_FULL;
			REQ_POP, REQ_PEEK: if (count_q == '0) stat_d = STAT_EMPTY;
			default: stat_d = STAT_OK;
		endcase
	end

	// next state and store accesses
	always_comb begin
		state_d  = state_q;
		rd_addr0 = '0;
		rd_addr1 = '0;
		wr_en    = 1'b0;
		wr_data  = x_q;
		unique case (state_q)
			S_IDLE: begin
				rd_addr0 = (req_type == REQ_PUSH) ? slot_addr(cnt_inc >> 1) : '0;
				rd_addr1 = slot_addr(count_q);
				if (accept) begin
					unique case (req_type)
						REQ_PUSH: begin
							if (cnt_full) begin
								state_d = S_FIN;
							end else if (cnt_inc == SW'(1)) begin
								state_d = S_PLACE;
							end else begin
								state_d = S_UP;
							end
						end
						REQ_POP, REQ_PEEK: begin
							state_d = (count_q == '0) ? S_FIN : S_LOAD;
						end
						default: state_d = S_FIN;
					endcase
				end
			end
			S_LOAD: begin
				rd_addr0 = AW'(1);
				rd_addr1 = AW'(2);
				if (req_q == REQ_PEEK) begin
					state_d = S_FIN;
				end else if (count_q >= SW'(2)) begin
					state_d = S_DOWN;
				end else if (count_q == SW'(1)) begin
					state_d = S_PLACE;
				end else begin
					state_d = S_FIN;
				end
			end
			S_UP: begin
				wr_en    = 1'b1;
				wr_data  = up_go ? rd_data0 : x_q;
				rd_addr0 = slot_addr(up_par >> 1);
				if (!up_go) begin
					state_d = S_FIN;
				end else if (up_par == SW'(1)) begin
					state_d = S_PLACE;
				end
			end
			S_DOWN: begin
				wr_en    = 1'b1;
				wr_data  = dn_go ? dn_cval : x_q;
				rd_addr0 = slot_addr(dn_next_l[SW-1:0]);
				rd_addr1 = slot_addr(dn_next_l[SW-1:0] | SW'(1));
				if (!dn_go) begin
					state_d = S_FIN;
				end else if (!dn_more) begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				wr_en   = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign wr_addr = slot_addr(pos_q);

	// hold state and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (req_type == REQ_PUSH && !cnt_full) begin
					count_q <= cnt_inc;
				end else if (req_type == REQ_POP && count_q != '0) begin
					count_q <= cnt_dec;
				end
			end
		end
	end

	// advance the moving word, its slot and the result
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q        <= req_t'(req_type);
			x_q          <= value;
			pos_q        <= cnt_inc;
			res_value_q  <= '0;
			res_status_q <= stat_d;
		end
		if (state_q == S_LOAD) begin
			res_value_q <= rd_data0;
			x_q         <= rd_data1;
			pos_q       <= SW'(1);
		end
		if (state_q == S_UP && up_go) begin
			pos_q <= up_par;
		end
		if (state_q == S_DOWN && dn_go) begin
			pos_q <= dn_csel;
		end
	end

	assign res.vld    = (state_q == S_FIN);
	assign res.value  = res_value_q;
	assign res.status = res_status_q;
	assign count      = count_q;

	`HBPQ_ASSERT_IMPL(a_cnt_max, 1'b1, count_q <= SW'(CAPACITY), "entry count above capacity")
	`HBPQ_ASSERT_IMPL(a_wr_in_heap, wr_en, (pos_q != '0) && (pos_q <= count_q), "store write outside heap")
	`HBPQ_ASSERT_IMPL(a_down_child, state_q == S_DOWN, dn_l <= cnt_ext, "sift down without a child")
	`HBPQ_ASSERT_NEXT(a_push_count, accept && (req_type == REQ_PUSH) && !cnt_full, count_q == $past(cnt_inc), "push did not grow count")

endmodule

// ===== sv/binary_heap_priority_queue.sv =====
// From acceptance to output valid: a rejected or unused request goes straight to the result,
// a peek reads the root first, a push climbs the heap level by level, and a pop reads the root
// and last word, then descends level by level; a result also waits while the output is stalled.
// One request at a time: the next word can be taken in the cycle after the result word is loaded,
// and each heap level is one read-modify-write of the store.
// Reset clears the entry count and the order register to largest-first; store left undefined.
`timescale 1ns / 1ps

module binary_heap_priority_queue #(
	parameter int unsigned CAPACITY = hbpq_pkg::CAPACITY_DEF,
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1),
	localparam int unsigned AW = $clog2(CAPACITY)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic                               cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         req_type,
	input  logic signed [hbpq_pkg::DATA_W-1:0] value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [hbpq_pkg::DATA_W-1:0] out_value,
	output logic [CNT_W-1:0]                   count,
	output logic [1:0]                         status
);
	import hbpq_pkg::*;

	logic                     heap_order_q;
	seq_res_t                 res;
	logic [CNT_W-1:0]         seq_count;
	logic                     out_free;
	logic                     out_load;
	logic [AW-1:0]            rd_addr0;
	logic [AW-1:0]            rd_addr1;
	logic signed [DATA_W-1:0] rd_data0;
	logic signed [DATA_W-1:0] rd_data1;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic signed [DATA_W-1:0] wr_data;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_value_q;
	logic [CNT_W-1:0]         out_count_q;
	status_t                  out_status_q;

	// hold the order register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_order_q <= 1'b0;
		end else if (cfg_we) begin
			heap_order_q <= cfg_wdata;
		end
	end

	hbpq_mem #(
		.DEPTH(CAPACITY)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr0(rd_addr0),
		.rd_addr1(rd_addr1),
		.rd_data0(rd_data0),
		.rd_data1(rd_data1)
	);

	hbpq_seq #(
		.CAPACITY(CAPACITY)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.heap_order(heap_order_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.value     (value),
		.res       (res),
		.count     (seq_count),
		.out_free  (out_free),
		.rd_addr0  (rd_addr0),
		.rd_addr1  (rd_addr1),
		.rd_data0  (rd_data0),
		.rd_data1  (rd_data1),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// output register is free when empty or being drained
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = res.vld && out_free;

	// hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q  <= res.value;
			out_count_q  <= seq_count;
			out_status_q <= res.status;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign count     = out_count_q;
	assign status    = out_status_q;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking bench for binary_heap_priority_queue: a scoreboard class keeps its own heap
// and predicts every reply, and plain tasks drive the request and register ports.
// Depends on hbpq_pkg and the RTL of the heap queue only.
`timescale 1ns / 1ps

module tb_top;
	import hbpq_pkg::*;

	localparam int unsigned DEPTH       = 1024;
	localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
	localparam logic [1:0]  REQ_UNUSED  = 2'd3;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned LONG_HOLD   = 300;
	localparam int unsigned SHOWN_MAX   = 10;

	typedef logic signed [DATA_W-1:0] word_t;

	typedef struct {
		word_t            root;
		logic [CNT_W-1:0] fill;
		status_t          stat;
	} reply_t;

	// Shadow heap plus the queue of replies still owed by the block
	class heap_scoreboard;
		word_t       slots [1:DEPTH];
		int unsigned fill;
		logic        min_first;
		reply_t      replies_due[$];
		int unsigned mismatches;
		int unsigned word_no;

		function new();
			fill = 0;
			min_first = 1'b0;
			mismatches = 0;
			word_no = 0;
		endfunction

		// strict order only: equal values never swap
		function bit outranks(word_t a, word_t b);
			return min_first ? (a < b) : (a > b);
		endfunction

		function void swap_slots(int unsigned i, int unsigned j);
			word_t t;
			t = slots[i];
			slots[i] = slots[j];
			slots[j] = t;
		endfunction

		function void heap_lift(int unsigned pos);
			while (pos > 1 && outranks(slots[pos], slots[pos / 2])) begin
				swap_slots(pos, pos / 2);
				pos = pos / 2;
			end
		endfunction

		// walk the new root down; on a tie between children take the right one
		function void heap_sink();
			int unsigned pos, lft, rgt;
			bit lb, rb;
			pos = 1;
			while (1'b1) begin
				lft = pos * 2;
				rgt = lft + 1;
				if (rgt <= fill) begin
					lb = outranks(slots[lft], slots[pos]);
					rb = outranks(slots[rgt], slots[pos]);
					if (!lb && !rb)
						return;
					if (outranks(slots[lft], slots[rgt])) begin
						swap_slots(lft, pos);
						pos = lft;
					end else begin
						swap_slots(rgt, pos);
						pos = rgt;
					end
				end else begin
					if (lft <= fill && outranks(slots[lft], slots[pos]))
						swap_slots(lft, pos);
					return;
				end
			end
		endfunction

		// Apply one accepted request to the shadow heap and queue its reply
		function void note_request(logic [1:0] code, word_t val);
			reply_t r;
			r.root = '0;
			r.stat = STAT_OK;
			case (code)
				REQ_PUSH: begin
					if (fill >= DEPTH) begin
						r.stat = STAT_FULL;
					end else begin
						fill++;
						slots[fill] = val;
						heap_lift(fill);
					end
				end
				REQ_POP: begin
					if (fill == 0) begin
						r.stat = STAT_EMPTY;
					end else begin
						r.root = slots[1];
						slots[1] = slots[fill];
						fill--;
						heap_sink();
					end
				end
				REQ_PEEK: begin
					if (fill == 0)
						r.stat = STAT_EMPTY;
					else
						r.root = slots[1];
				end
				default: ;
			endcase
			r.fill = CNT_W'(fill);
			replies_due.push_back(r);
		endfunction

		// Compare one delivered reply with the oldest one owed
		function void check_reply(word_t v, logic [CNT_W-1:0] c, logic [1:0] s);
			reply_t r;
			word_no++;
			if (replies_due.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_MAX)
					$display("%0t: reply word %0d not owed: value %0d count %0d status %0d",
						$time, word_no, v, c, s);
				return;
			end
			r = replies_due.pop_front();
			if (v !== r.root || c !== r.fill || s !== r.stat) begin
				mismatches++;
				if (mismatches <= SHOWN_MAX) begin
					$write("%0t: reply word %0d expected value %0d count %0d status %0d,",
						$time, word_no, r.root, r.fill, r.stat);
					$display(" got value %0d count %0d status %0d", v, c, s);
				end
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_wdata;
	logic             in_valid;
	logic             in_stall;
	logic [1:0]       req_type;
	word_t            value;
	logic             out_valid;
	logic             out_stall;
	word_t            out_value;
	logic [CNT_W-1:0] count;
	logic [1:0]       status;

	heap_scoreboard sb = new();
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_left = 0;
	int unsigned quiet_cycles = 0;

	always #6 clk = ~clk;

	binary_heap_priority_queue #(
		.CAPACITY(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_value(out_value),
		.count(count),
		.status(status)
	);

	// Receiver: hold off for a long stretch on request, else stall at random
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Check every reply word taken from the block
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall)
			sb.check_reply(out_value, count, status);
	end

	// Abort when neither side has moved a word for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Offer one request word, idling first at random, and note it once taken
	task automatic send_word(input logic [1:0] code, input word_t val);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			value <= $urandom;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= code;
		value <= val;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_request(code, val);
	endtask

	// Mostly wide random values, some small ones to force ties, some extremes
	function automatic word_t pick_value();
		case ($urandom_range(9))
			6, 7: return word_t'(int'($urandom_range(8)) - 4);
			8: return word_t'(32'h7FFF_FFFF);
			9: return word_t'(32'h8000_0000);
			default: return word_t'($urandom);
		endcase
	endfunction

	task automatic send_mixed(input int unsigned n, input int unsigned push_pct,
		input int unsigned pop_pct);
		int unsigned roll;
		logic [1:0] code;
		for (int unsigned i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			if (roll < push_pct)
				code = REQ_PUSH;
			else if (roll < push_pct + pop_pct)
				code = REQ_POP;
			else if (roll < 96)
				code = REQ_PEEK;
			else
				code = REQ_UNUSED;
			send_word(code, pick_value());
		end
	endtask

	// Drain all owed replies, then write the order register while idle
	task automatic write_order(input logic ord);
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.replies_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= ord;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.min_first = ord;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_PUSH;
		value = '0;
		out_stall = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty requests, unused code, extremes and ties, full drain
		write_order(1'b0);
		send_word(REQ_PEEK, word_t'(32'h1234_5678));
		send_word(REQ_POP, word_t'(32'hFFFF_FFFF));
		send_word(REQ_UNUSED, word_t'(32'hFFFF_FFFF));
		send_word(REQ_PUSH, word_t'(32'h7FFF_FFFF));
		send_word(REQ_PUSH, word_t'(32'h8000_0000));
		send_word(REQ_PUSH, '0);
		send_word(REQ_PUSH, word_t'(-1));
		send_word(REQ_PUSH, word_t'(1));
		send_word(REQ_PUSH, word_t'(32'h7FFF_FFFF));
		send_word(REQ_PUSH, word_t'(32'h8000_0000));
		send_word(REQ_PEEK, '0);
		send_word(REQ_UNUSED, word_t'(32'h5555_AAAA));
		repeat (7) send_word(REQ_POP, word_t'(32'hAAAA_5555));
		send_word(REQ_POP, '0);
		send_word(REQ_PEEK, '0);

		// Smallest first, sender lightly idle, receiver mostly stalled
		send_idle_pct = 33;
		recv_idle_pct = 63;
		write_order(1'b1);
		send_mixed(180, 55, 30);

		// Swap to largest first over the live heap; long receiver hold-off midway
		send_idle_pct = 63;
		recv_idle_pct = 33;
		write_order(1'b0);
		send_mixed(60, 55, 30);
		hold_left = LONG_HOLD;
		send_mixed(120, 55, 30);

		// No idling: grow the heap with push-heavy traffic for deeper walks
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_order(1'b1);
		send_mixed(150, 80, 10);
		send_word(REQ_PEEK, '0);

		// Flip order on the grown heap and drain hard
		write_order(1'b0);
		send_mixed(120, 20, 70);

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.replies_due.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.mismatches == 0 && sb.replies_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/hbpq_pkg.sv
sv/hbpq_mem.sv
sv/hbpq_seq.sv
sv/binary_heap_priority_queue.sv
verif/tb_top.sv
